/* design/dur_pkg.sv */
`timescale 1ns / 1ps

package dur_pkg;

  localparam int unsigned FIFO_DEPTH = 64;

  localparam logic [13:0] DIV_LO_RESET   = 14'd243;
  localparam logic [2:0]  DIV_HI_RESET   = 3'd0;
  localparam logic [7:0]  FRAME_RESET    = 8'h18;
  localparam logic [1:0]  LOOPBACK_RESET = 2'b11;
  localparam logic [7:0]  SEL_READ_BIT   = 8'h40;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RECV  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PORT_DATA   = 2'd0,
    PORT_SELECT = 2'd1,
    PORT_FRAME  = 2'd2,
    PORT_STATUS = 2'd3
  } port_e;

  // per channel operation decoded from one item
  typedef struct packed {
    logic       tick;
    logic       wr;
    logic       rd;
    logic       rx;
    logic       div_hi_we;
    port_e      port;
    logic [7:0] data;
  } chan_op_t;

  // per channel response to one item
  typedef struct packed {
    logic [7:0] rd_val;
    logic       pop;
    logic       txv;
    logic       txi;
    logic       rxi;
  } chan_resp_t;

endpackage

/* design/dur_chan.sv */
`timescale 1ns / 1ps

module dur_chan #(
  parameter int unsigned FifoDepth = dur_pkg::FIFO_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  dur_pkg::chan_op_t    op_i,
  input  logic                 loopback_i,
  output dur_pkg::chan_resp_t  resp_o,
  output logic [7:0]           rx_byte_o,
  output logic [7:0]           tx_byte_o
);

  localparam int unsigned AW = $clog2(FifoDepth);
  localparam int unsigned FW = $clog2(FifoDepth + 1);
  localparam int unsigned SW = FW + 1;
  localparam logic [FW-1:0] Full     = FW'(FifoDepth);
  localparam logic [AW-1:0] LastSlot = AW'(FifoDepth - 1);
  localparam logic [FW+1:0] HighMark = (FW + 2)'(3 * FifoDepth);

  logic [AW-1:0] tx_head_q, tx_head_d, rx_head_q, rx_head_d;
  logic [FW-1:0] tx_fill_q, tx_fill_d, rx_fill_q, rx_fill_d;
  logic [13:0]   div_lo_q, div_lo_d;
  logic [2:0]    div_hi_q, div_hi_d;
  logic [7:0]    frame_q, frame_d;
  logic          sending_q, sending_d;
  logic [20:0]   timer_q, timer_d;
  logic          ovf_q, ovf_d;

  logic [7:0]    tx_mem [FifoDepth];
  logic [7:0]    rx_mem [FifoDepth];
  logic [7:0]    tx_rd_q, rx_rd_q;

  // receive writes land in the cycle after the item, so loopback bytes can come from tx_rd_q
  logic          wr_pend_q;
  logic          wr_lb_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    wr_data_q;
  logic [7:0]    rx_wdata;

  logic [16:0]   presc;
  logic [16:0]   presc_eff;
  logic [3:0]    char_bits;
  logic [20:0]   byte_time;
  logic [20:0]   timer_dec;
  logic          start;
  logic          rx_in;
  logic          rx_lb;
  logic          rx_push;
  logic          tx_we;
  logic [AW-1:0] tx_slot;
  logic [AW-1:0] rx_slot;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] h);
    return (h == LastSlot) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [FW-1:0] f);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(f);
    if (s >= SW'(FifoDepth)) begin
      s = s - SW'(FifoDepth);
    end
    return s[AW-1:0];
  endfunction

  assign presc      = {div_hi_q, div_lo_q};
  assign presc_eff  = (presc == '0) ? 17'd1 : presc;
  assign char_bits  = 4'd7 + {2'b00, frame_q[4:3]} + {3'b000, frame_q[2]} + {3'b000, frame_q[0]};
  assign byte_time  = 21'(presc_eff) * 21'(char_bits);
  assign timer_dec  = (timer_q != '0) ? timer_q - 21'd1 : timer_q;
  assign tx_slot    = slot_of(tx_head_q, tx_fill_q);
  assign rx_slot    = slot_of(rx_head_q, rx_fill_q);
  assign rx_wdata   = wr_lb_q ? tx_rd_q : wr_data_q;

  always_comb begin
    tx_head_d = tx_head_q;
    tx_fill_d = tx_fill_q;
    rx_head_d = rx_head_q;
    rx_fill_d = rx_fill_q;
    div_lo_d  = div_lo_q;
    div_hi_d  = div_hi_q;
    frame_d   = frame_q;
    sending_d = sending_q;
    timer_d   = timer_q;
    ovf_d     = ovf_q;
    resp_o    = '0;
    start     = 1'b0;
    rx_in     = 1'b0;
    rx_lb     = 1'b0;
    rx_push   = 1'b0;
    tx_we     = 1'b0;

    // transmitter, frozen while the channel is held in reset
    if (op_i.tick && !frame_q[7]) begin
      if (sending_q) begin
        timer_d = timer_dec;
        if (timer_dec == '0) begin
          sending_d = 1'b0;
          if (tx_fill_q != '0) begin
            start = 1'b1;
          end else begin
            resp_o.txi = 1'b1;
          end
        end
      end else if (tx_fill_q != '0) begin
        start = 1'b1;
      end
    end

    if (start) begin
      tx_head_d = wrap_next(tx_head_q);
      tx_fill_d = tx_fill_q - 1'b1;
      sending_d = 1'b1;
      timer_d   = byte_time;
      if (loopback_i) begin
        rx_in = 1'b1;
        rx_lb = 1'b1;
      end else begin
        resp_o.txv = 1'b1;
      end
    end

    if (op_i.rx) begin
      rx_in = 1'b1;
    end

    if (rx_in) begin
      if (rx_fill_q == Full) begin
        ovf_d = 1'b1;
      end else begin
        rx_push    = 1'b1;
        rx_fill_d  = rx_fill_q + 1'b1;
        resp_o.rxi = 1'b1;
      end
    end

    if (op_i.div_hi_we) begin
      div_hi_d = op_i.data[2:0];
    end

    if (op_i.wr) begin
      case (op_i.port)
        dur_pkg::PORT_DATA: begin
          if (op_i.data[7]) begin
            div_lo_d = {op_i.data[6:0], div_lo_q[6:0]};
          end else begin
            div_lo_d = {div_lo_q[13:7], op_i.data[6:0]};
          end
        end
        dur_pkg::PORT_FRAME: begin
          frame_d = op_i.data;
          if (op_i.data[7]) begin
            tx_head_d = '0;
            tx_fill_d = '0;
            rx_head_d = '0;
            rx_fill_d = '0;
            sending_d = 1'b0;
            timer_d   = '0;
            ovf_d     = 1'b0;
          end
        end
        dur_pkg::PORT_STATUS: begin
          if (tx_fill_q != Full) begin
            tx_we     = 1'b1;
            tx_fill_d = tx_fill_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (op_i.rd) begin
      case (op_i.port)
        dur_pkg::PORT_DATA: begin
          if (rx_fill_q != '0) begin
            resp_o.pop = 1'b1;
            rx_head_d  = wrap_next(rx_head_q);
            rx_fill_d  = rx_fill_q - 1'b1;
          end
        end
        dur_pkg::PORT_SELECT: begin
          resp_o.rd_val = {5'b00000, div_hi_q};
        end
        dur_pkg::PORT_FRAME: begin
          resp_o.rd_val = frame_q;
        end
        dur_pkg::PORT_STATUS: begin
          resp_o.rd_val = {3'b000,
                           (tx_fill_q == '0) && !sending_q,
                           {rx_fill_q, 2'b00} >= HighMark,
                           ovf_q,
                           tx_fill_q == Full,
                           rx_fill_q != '0};
          ovf_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q <= '0;
      tx_fill_q <= '0;
      rx_head_q <= '0;
      rx_fill_q <= '0;
      div_lo_q  <= dur_pkg::DIV_LO_RESET;
      div_hi_q  <= dur_pkg::DIV_HI_RESET;
      frame_q   <= dur_pkg::FRAME_RESET;
      sending_q <= 1'b0;
      timer_q   <= '0;
      ovf_q     <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= adv_i && rx_push;
      if (adv_i) begin
        tx_head_q <= tx_head_d;
        tx_fill_q <= tx_fill_d;
        rx_head_q <= rx_head_d;
        rx_fill_q <= rx_fill_d;
        div_lo_q  <= div_lo_d;
        div_hi_q  <= div_hi_d;
        frame_q   <= frame_d;
        sending_q <= sending_d;
        timer_q   <= timer_d;
        ovf_q     <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wr_lb_q   <= rx_lb;
      wr_addr_q <= rx_slot;
      wr_data_q <= op_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tx_we) begin
      tx_mem[tx_slot] <= op_i.data;
    end
    if (adv_i) begin
      tx_rd_q <= tx_mem[tx_head_q];
    end
  end

  // write-first on the pending receive write so a pop right behind a push sees the byte
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      rx_mem[wr_addr_q] <= rx_wdata;
    end
    if (adv_i) begin
      rx_rd_q <= (wr_pend_q && (wr_addr_q == rx_head_q)) ? rx_wdata : rx_mem[rx_head_q];
    end
  end

  assign rx_byte_o = rx_rd_q;
  assign tx_byte_o = tx_rd_q;

endmodule

/* design/dual_uart_register_block.sv */
`timescale 1ns / 1ps

// Two UART channels behind four byte ports, driven one item per transfer.
// Input stream: tdata carries the byte, tuser carries command, port and the
// receiving channel. Command tick advances both transmitter timers by one
// count; write and read act on the channel picked by the select port; receive
// pushes a serial byte into the named channel's receive FIFO.
// Output stream: one result per item with the read value, the transmitted
// bytes with their valid bits, and the transmit and receive interrupt bits.
// Configuration: a separate write channel sets the loopback mask, always ready.
// Throughput: one item per clock cycle while results are taken; the channel
// logic is combinational between the input register and the result register.
// Path: an item taken into the input register passes the channel logic into the
// result register as soon as the result stage is free; FIFO reads come out of
// registered memory reads in the result stage.
// Reset: FIFOs empty, transmitters idle, prescaler 243, frame 8N1, channel 0
// selected, loopback on for both channels. No clearing pass is needed.
// Stall: a held result keeps the input register filled with the next item;
// after that tready drops until the result is taken.

module dual_uart_register_block #(
  parameter int unsigned FifoDepth = dur_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data
  input  logic [4:0]  s_axis_tuser,   // command[1:0], port[3:2], channel[4]

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], tx_valid[9:8], tx_byte_zero[17:10], tx_byte_one[25:18],
  // tx_irq[27:26], rx_irq[29:28], zero[31:30]
  output logic [31:0] m_axis_tdata,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  logic                s1_valid_q, s1_valid_d;
  dur_pkg::cmd_e       cmd_q;
  dur_pkg::port_e      port_q;
  logic [7:0]          data_q;
  logic                chan_q;
  logic                sel_q, sel_d;
  logic [1:0]          loopback_q;

  logic                in_xfer;
  logic                adv;
  logic                out_valid_q, out_valid_d;

  dur_pkg::chan_op_t   op [2];
  dur_pkg::chan_resp_t resp [2];
  logic [7:0]          rx_byte [2];
  logic [7:0]          tx_byte [2];

  logic [7:0]          rd_val;
  logic [7:0]          out_rd_q;
  logic                out_pop_q;
  logic                out_popch_q;
  logic [1:0]          out_txv_q, out_txi_q, out_rxi_q;
  logic [7:0]          read_data;

  assign cfg_ready_o   = 1'b1;
  assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    sel_d = sel_q;
    if (cmd_q == dur_pkg::CMD_WRITE && port_q == dur_pkg::PORT_SELECT) begin
      sel_d = data_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      loopback_q  <= dur_pkg::LOOPBACK_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        sel_q <= sel_d;
      end
      if (cfg_valid_i) begin
        loopback_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= dur_pkg::cmd_e'(s_axis_tuser[1:0]);
      port_q <= dur_pkg::port_e'(s_axis_tuser[3:2]);
      chan_q <= s_axis_tuser[4];
      data_q <= s_axis_tdata;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_chan
    always_comb begin
      op[c].tick      = cmd_q == dur_pkg::CMD_TICK;
      op[c].wr        = (cmd_q == dur_pkg::CMD_WRITE) && (sel_q == 1'(c));
      op[c].rd        = (cmd_q == dur_pkg::CMD_READ) && (sel_q == 1'(c));
      op[c].rx        = (cmd_q == dur_pkg::CMD_RECV) && (chan_q == 1'(c));
      // the prescaler top part goes to the newly selected channel
      op[c].div_hi_we = (cmd_q == dur_pkg::CMD_WRITE) && (port_q == dur_pkg::PORT_SELECT)
                        && data_q[4] && (data_q[6] == 1'(c));
      op[c].port      = port_q;
      op[c].data      = data_q;
    end

    dur_chan #(
      .FifoDepth (FifoDepth)
    ) u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .op_i       (op[c]),
      .loopback_i (loopback_q[c]),
      .resp_o     (resp[c]),
      .rx_byte_o  (rx_byte[c]),
      .tx_byte_o  (tx_byte[c])
    );
  end

  always_comb begin
    rd_val = resp[sel_q].rd_val;
    if (cmd_q == dur_pkg::CMD_READ && port_q == dur_pkg::PORT_SELECT && sel_q) begin
      rd_val = rd_val | dur_pkg::SEL_READ_BIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rd_q    <= rd_val;
      out_pop_q   <= resp[sel_q].pop;
      out_popch_q <= sel_q;
      out_txv_q   <= {resp[1].txv, resp[0].txv};
      out_txi_q   <= {resp[1].txi, resp[0].txi};
      out_rxi_q   <= {resp[1].rxi, resp[0].rxi};
    end
  end

  // popped bytes come straight from the registered FIFO read
  assign read_data     = out_pop_q ? rx_byte[out_popch_q] : out_rd_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00,
                          out_rxi_q,
                          out_txi_q,
                          out_txv_q[1] ? tx_byte[1] : 8'h00,
                          out_txv_q[0] ? tx_byte[0] : 8'h00,
                          out_txv_q,
                          read_data};

endmodule

/* design/dur_checker.sv */
`timescale 1ns / 1ps

module dur_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // with the result stage empty the input side must be open
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result stage");

  // a channel either starts a byte or reports an empty transmitter, never both
  a_tx_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[9:8] & m_axis_tdata[27:26]) == 2'b00))
    else $error("tx valid and tx irq on the same channel");

  // a sent byte goes either out or into loopback
  a_tx_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[9:8] & m_axis_tdata[29:28]) == 2'b00))
    else $error("byte both transmitted and looped back");

  // a nonzero read value never comes with a transmitter event: reads and ticks are apart
  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] != 8'h00)
    |-> (m_axis_tdata[9:8] == 2'b00) && (m_axis_tdata[27:26] == 2'b00))
    else $error("read value alongside transmitter event");

endmodule

bind dual_uart_register_block dur_checker u_dur_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
